/* sv/ofc_pkg.sv */
// Package: shared types, sizes and command/status structs of the overlap-add FIR convolver.
`timescale 1ns / 1ps
`default_nettype none

package ofc_pkg;

	localparam int MAX_TAPS      = 7;
	localparam int SAMPLE_BITS   = 16;
	localparam int COEF_BITS     = 16;
	localparam int OUT_BITS      = 34;
	localparam int TAP_CNT_BITS  = 3;
	localparam int PROD_BITS     = SAMPLE_BITS + COEF_BITS;
	localparam int TAP_IDX_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CFG_IDX_W     = $clog2(MAX_TAPS + 1);

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = '0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = CFG_IDX_W'(1);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          final_sample;
	} in_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] out_value;
		logic                       out_last;
	} out_t;

	// controller -> datapath
	typedef struct packed {
		logic                 load;       // shift the new sample in
		logic                 shift_zero; // shift a zero in for a tail output
		logic                 clear_hist; // flush the delay line after the last output
		logic                 mul_en;     // multiply tap tap_idx
		logic                 acc_clr;
		logic                 acc_add;
		logic [TAP_IDX_W-1:0] tap_idx;
		logic                 emit;       // write the output register
		logic                 last;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [TAP_CNT_BITS-1:0] taps;    // taps in use, 1 .. MAX_TAPS
	} status_t;

endpackage

`default_nettype wire

/* sv/overlap_add_fir_convolver.sv */
// Top level: overlap-add FIR convolver, controller plus datapath.
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one signed sample per transfer;
//   final_sample marks the last sample of a signal.
//   Output channel (out_valid/out_ready/out_data) delivers one full-precision sum
//   per sample, plus taps-1 tail sums after a final sample; out_last flags the
//   very last sum of the convolution.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   index 0 is tap_count, indexes 1..7 are coef_0..coef_6. Write it only idle.
// Timing:
//   One shared 16x16 multiplier runs one tap per cycle; after the last tap the
//   sum is written to the output register. Each tail sum reruns the tap loop.
//   in_ready is high only while no sample is in the tap loop.
// Reset (arst_n low): tap_count 1, coef_0 1, other coefficients and the delay
//   line zero, no result pending.
// Stall: a result waits in the output register; the next sample is still taken
//   and its sum is computed, then held until the pending result transfers.
`timescale 1ns / 1ps
`default_nettype none

module overlap_add_fir_convolver
	import ofc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_t                  in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_t                      out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COEF_BITS-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	// registers take every write at once
	assign cfg_ready = 1'b1;

	ofc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_final  (in_data.final_sample),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	ofc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (in_data.sample),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* sv/ofc_dp.sv */
// Datapath: configuration registers, delay line, shared multiplier, accumulator, output register.
`timescale 1ns / 1ps
`default_nettype none

module ofc_dp
	import ofc_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [COEF_BITS-1:0]          cfg_data,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire cmd_t                          cmd,
	output status_t                            status,
	output out_t                               out_data
);

	logic [TAP_CNT_BITS-1:0]      tap_count_q;
	logic signed [COEF_BITS-1:0]  coef_q [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] hist_q [MAX_TAPS];
	logic signed [PROD_BITS-1:0]  prod_q;
	logic [OUT_BITS-1:0]          acc_q;
	out_t                         out_q;

	// zero means one tap, anything above the maximum saturates
	always_comb begin
		if (tap_count_q == '0) begin
			status.taps = TAP_CNT_BITS'(1);
		end else if (tap_count_q > TAP_CNT_BITS'(MAX_TAPS)) begin
			status.taps = TAP_CNT_BITS'(MAX_TAPS);
		end else begin
			status.taps = tap_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_CNT_BITS'(1);
		end else if (cfg_we && cfg_index == REG_TAP_COUNT) begin
			tap_count_q <= cfg_data[TAP_CNT_BITS-1:0];
		end
	end

	for (genvar i = 0; i < MAX_TAPS; i++) begin : g_coef
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				coef_q[i] <= (i == 0) ? COEF_BITS'(1) : '0;
			end else if (cfg_we && cfg_index == REG_COEF_0 + CFG_IDX_W'(i)) begin
				coef_q[i] <= cfg_data;
			end
		end
	end

	// delay line: entry 0 is the newest sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) hist_q[i] <= '0;
		end else if (cmd.clear_hist) begin
			for (int i = 0; i < MAX_TAPS; i++) hist_q[i] <= '0;
		end else if (cmd.load || cmd.shift_zero) begin
			hist_q[0] <= cmd.load ? sample : '0;
			for (int i = 1; i < MAX_TAPS; i++) hist_q[i] <= hist_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= PROD_BITS'(coef_q[cmd.tap_idx]) * PROD_BITS'(hist_q[cmd.tap_idx]);
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + OUT_BITS'(prod_q);
		end
		if (cmd.emit) begin
			out_q.out_value <= acc_q + OUT_BITS'(prod_q);
			out_q.out_last  <= cmd.last;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

/* sv/ofc_ctrl.sv */
// Controller: sequences the tap loop, tail outputs and the output handshake.
`timescale 1ns / 1ps
`default_nettype none

module ofc_ctrl
	import ofc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    in_final,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MAC  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t               state_q, state_d;
	logic [TAP_IDX_W-1:0] k_q, k_d;
	logic [TAP_IDX_W-1:0] tails_q, tails_d;
	logic                 fin_q, fin_d;
	logic                 out_valid_q;
	logic                 accept;
	logic                 last_tap;
	logic                 slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign last_tap  = (TAP_CNT_BITS'(k_q) == status.taps - TAP_CNT_BITS'(1));
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		tails_d = tails_q;
		fin_d   = fin_q;
		cmd     = '0;
		cmd.tap_idx = k_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					fin_d    = in_final;
					tails_d  = in_final ? TAP_IDX_W'(status.taps - TAP_CNT_BITS'(1)) : '0;
					k_d      = '0;
					state_d  = ST_MAC;
				end
			end
			ST_MAC: begin
				cmd.mul_en  = 1'b1;
				cmd.acc_clr = (k_q == '0);
				cmd.acc_add = (k_q != '0);
				if (last_tap) begin
					state_d = ST_EMIT;
				end else begin
					k_d = k_q + TAP_IDX_W'(1);
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					cmd.last = fin_q && (tails_q == '0);
					if (tails_q != '0) begin
						// next tail output: zero in, rerun the taps
						cmd.shift_zero = 1'b1;
						tails_d        = tails_q - TAP_IDX_W'(1);
						k_d            = '0;
						state_d        = ST_MAC;
					end else begin
						cmd.clear_hist = fin_q;
						state_d        = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			tails_q     <= '0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			tails_q <= tails_d;
			fin_q   <= fin_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while a result waits");

	a_tap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (TAP_CNT_BITS'(k_q) < status.taps))
		else $error("tap index beyond taps in use");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> (state_q == ST_IDLE))
		else $error("last output not followed by idle");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_MAC && k_q == '0))
		else $error("accepted sample did not start the tap loop");
`endif

endmodule

`default_nettype wire

/* bench/tb.sv */
// Testbench for the overlap-add FIR convolver: self-checking sums, kernels and backpressure.
`timescale 1ns / 1ps

module tb
	import ofc_pkg::*;
();

	// Slowest run: about 410 samples, each with up to seven results, plus receiver
	// stalls and sender gaps. Allow several times the length of that run.
	localparam int CYCLE_LIMIT   = 400000;
	// Quiet cycles after the last result: one full seven-tap sample plus margin.
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES   = 300;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_t                 out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_BITS-1:0] cfg_data;

	// Shadow copy of the configuration and the delay line.
	logic [TAP_CNT_BITS-1:0]      tap_reg;
	logic signed [COEF_BITS-1:0]  coef_reg [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] hist_q  [MAX_TAPS-1];

	// Sums still owed by the block, oldest first.
	out_t expected_sums [$];

	int err_count;
	int cycle_count;
	int signal_left;   // samples left in the current signal
	int burst_left;    // back-to-back transfers left before the next sender gap
	bit tx_steady;     // sender offers without gaps
	bit rx_steady;     // receiver never stalls
	int rx_hold_req;   // request for a long receiver hold, in cycles

	overlap_add_fir_convolver u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t timeout with %0d sums outstanding", $time, expected_sums.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// A tap count of zero still means one tap; three bits cannot exceed seven.
	function automatic int taps_in_use();
		return (tap_reg == '0) ? 1 : int'(tap_reg);
	endfunction

	// Shift one sample into the delay line and return the kernel sum over the
	// taps in use, wrapped to the output width.
	function automatic logic signed [OUT_BITS-1:0] shift_and_sum(
		logic signed [SAMPLE_BITS-1:0] x);
		logic signed [SAMPLE_BITS-1:0] win [MAX_TAPS];
		longint acc;
		int k;
		win[0] = x;
		for (k = 1; k < MAX_TAPS; k++)
			win[k] = hist_q[k-1];
		for (k = 0; k < MAX_TAPS - 1; k++)
			hist_q[k] = win[k];
		acc = 0;
		for (k = 0; k < taps_in_use(); k++)
			acc += longint'(coef_reg[k]) * longint'(win[k]);
		return acc[OUT_BITS-1:0];
	endfunction

	// Queue the sums that one accepted sample owes: its own, then the tail of
	// a finished signal with zeros shifted in, then flush the delay line.
	function automatic void predict_sums(in_t item);
		out_t sum;
		int taps;
		int t;
		taps = taps_in_use();
		sum.out_value = shift_and_sum(item.sample);
		sum.out_last  = item.final_sample && (taps == 1);
		expected_sums.push_back(sum);
		if (item.final_sample) begin
			for (t = 1; t < taps; t++) begin
				sum.out_value = shift_and_sum('0);
				sum.out_last  = (t == taps - 1);
				expected_sums.push_back(sum);
			end
			for (t = 0; t < MAX_TAPS - 1; t++)
				hist_q[t] = '0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------

	always @(posedge clk) begin : result_check
		out_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_sums.size() == 0) begin
				err_count++;
				$display("%0t unexpected result: expected none, actual value %0d last %0b",
					$time, out_data.out_value, out_data.out_last);
			end else begin
				want = expected_sums.pop_front();
				if (out_data.out_value !== want.out_value) begin
					err_count++;
					$display("%0t out_value mismatch: expected %0d, actual %0d",
						$time, want.out_value, out_data.out_value);
				end
				if (out_data.out_last !== want.out_last) begin
					err_count++;
					$display("%0t out_last mismatch: expected %0b, actual %0b",
						$time, want.out_last, out_data.out_last);
				end
			end
		end
	end

	// Receiver: alternate ready runs and stall runs of random length, with
	// occasional long ready runs; honor a hold request by counting it down here.
	initial begin : rx_pattern
		int run_left;
		int hold_left;
		bit stalled;
		run_left  = 0;
		hold_left = 0;
		stalled   = 1'b0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold_req != 0) begin
				hold_left   = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (rx_steady) begin
				out_ready <= 1'b1;
			end else begin
				if (run_left == 0) begin
					stalled = !stalled;
					if (stalled)
						run_left = $urandom_range(1, 6);
					else
						run_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 14);
				end
				run_left--;
				out_ready <= !stalled;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one sample and hold it until the transfer; leave valid high so a
	// following sample can go out back to back.
	task automatic send_item(in_t item);
		in_data  <= item;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		predict_sums(item);
	endtask

	// Drop valid for a random gap at the end of each random burst.
	task automatic tx_gap();
		int gap;
		if (tx_steady)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 15);
		gap = $urandom_range(1, 8);
		in_valid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	// Stop offering and wait until every owed sum has arrived, then let the
	// pipeline settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_sums.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write tap_count, then the coefficients selected by the mask. Only call
	// this with the block idle.
	task automatic load_kernel(logic [COEF_BITS-1:0] tap_word,
		logic [MAX_TAPS-1:0][COEF_BITS-1:0] kernel, logic [MAX_TAPS-1:0] which);
		int r;
		int k;
		for (r = 0; r <= MAX_TAPS; r++) begin
			k = (r == 0) ? 0 : r - 1;
			if (r != 0 && !which[k])
				continue;
			cfg_valid <= 1'b1;
			cfg_index <= (r == 0) ? REG_TAP_COUNT : REG_COEF_0 + CFG_IDX_W'(k);
			cfg_data  <= (r == 0) ? tap_word : kernel[k];
			do @(posedge clk); while (cfg_ready !== 1'b1);
			if (r == 0)
				tap_reg = tap_word[TAP_CNT_BITS-1:0];
			else
				coef_reg[k] = kernel[k];
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [COEF_BITS-1:0] rand_coef();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return COEF_BITS'($urandom_range(0, 7) - 4);
			default: return COEF_BITS'($urandom);
		endcase
	endfunction

	// Send well-formed signals of random length: mostly 2 to 12 samples, some
	// single-sample signals, final_sample on the last of each.
	task automatic send_signals(int n);
		in_t item;
		int i;
		for (i = 0; i < n; i++) begin
			if (signal_left == 0)
				signal_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
			signal_left--;
			item.sample       = rand_sample();
			item.final_sample = (signal_left == 0);
			send_item(item);
			tx_gap();
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset kernel is a single unit tap: every sample passes straight through,
	// and a final sample carries out_last with no tail.
	task automatic test_reset_passthrough();
		in_t item;
		logic signed [SAMPLE_BITS-1:0] vals [5];
		int i;
		vals = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh5555};
		for (i = 0; i < 5; i++) begin
			item.sample       = vals[i];
			item.final_sample = (i == 4);
			send_item(item);
			tx_gap();
		end
		wait_drained();
	endtask

	// A tap count of zero acts as one tap; the upper data bits of the write
	// are masked off.
	task automatic test_tap_count_zero();
		logic [MAX_TAPS-1:0][COEF_BITS-1:0] kernel;
		in_t item;
		kernel    = '0;
		kernel[0] = 16'h8000;
		load_kernel(16'hFFF8, kernel, 7'b000_0001);
		item = '{sample: 16'sh8000, final_sample: 1'b0};
		send_item(item);
		item = '{sample: 16'sh3039, final_sample: 1'b1};
		send_item(item);
		item = '{sample: 16'sh0001, final_sample: 1'b1};
		send_item(item);
		wait_drained();
	endtask

	// Seven taps at the coefficient extremes with full-scale samples: the
	// largest positive and most negative sums, each followed by a six-sum tail.
	task automatic test_kernel_extremes();
		logic [MAX_TAPS-1:0][COEF_BITS-1:0] kernel;
		in_t item;
		int pass;
		int i;
		for (pass = 0; pass < 2; pass++) begin
			kernel = {MAX_TAPS{(pass == 0) ? 16'h8000 : 16'h7FFF}};
			load_kernel(16'h5557, kernel, '1);
			for (i = 0; i < MAX_TAPS; i++) begin
				item.sample       = 16'sh8000;
				item.final_sample = (i == MAX_TAPS - 1);
				send_item(item);
				tx_gap();
			end
			wait_drained();
		end
	endtask

	// Random kernels over several phases, each with random signals. Stretches
	// with no receiver stalls and with no sender gaps each fill one phase.
	task automatic test_random_kernels();
		logic [MAX_TAPS-1:0][COEF_BITS-1:0] kernel;
		logic [COEF_BITS-1:0] tap_word;
		int p;
		int k;
		for (p = 0; p < 10; p++) begin
			for (k = 0; k < MAX_TAPS; k++)
				kernel[k] = rand_coef();
			tap_word = COEF_BITS'($urandom);
			if (p == 0)
				tap_word[TAP_CNT_BITS-1:0] = 3'd7;
			load_kernel(tap_word, kernel, (p == 0) ? '1 : MAX_TAPS'($urandom));
			rx_steady = (p == 3);
			tx_steady = (p == 5);
			send_signals(32);
			rx_steady = 1'b0;
			tx_steady = 1'b0;
			wait_drained();
		end
	endtask

	// Hold the receiver off for a long stretch while the sender keeps offering,
	// so the block fills and stalls its input.
	task automatic test_output_hold();
		logic [MAX_TAPS-1:0][COEF_BITS-1:0] kernel;
		int k;
		for (k = 0; k < MAX_TAPS; k++)
			kernel[k] = rand_coef();
		load_kernel(16'h0007, kernel, '1);
		tx_steady   = 1'b1;
		rx_hold_req = HOLD_CYCLES;
		send_signals(40);
		tx_steady = 1'b0;
		wait_drained();
	endtask

	// Pause the sender until every owed sum has arrived, four times, often mid-signal.
	task automatic test_drain_pause();
		int chunk;
		for (chunk = 0; chunk < 4; chunk++) begin
			send_signals(7);
			wait_drained();
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		in_data     <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		err_count   = 0;
		signal_left = 0;
		burst_left  = 0;
		tx_steady   = 1'b0;
		rx_steady   = 1'b0;
		rx_hold_req = 0;
		// Mirror the reset state: one unit tap, empty delay line.
		tap_reg = 3'd1;
		for (int k = 0; k < MAX_TAPS; k++)
			coef_reg[k] = (k == 0) ? 16'sd1 : 16'sd0;
		for (int k = 0; k < MAX_TAPS - 1; k++)
			hist_q[k] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_passthrough();
		test_tap_count_zero();
		test_kernel_extremes();
		test_random_kernels();
		test_output_hold();
		test_drain_pause();

		wait_drained();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* overlap_add_fir_convolver.f */
sv/ofc_pkg.sv
sv/ofc_dp.sv
sv/ofc_ctrl.sv
sv/overlap_add_fir_convolver.sv
bench/tb.sv
